[rtl/ssi_pkg.sv]
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared types and constants of the sorted set insert unit: controller
// states, datapath command and status bundles, fixed field widths.
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int KEY_W   = 32;
  localparam int IDX_W   = 6;
  localparam int OUT_C_W = 7;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMPARE,
    ST_SHIFT_WR,
    ST_SHIFT_RD,
    ST_FINISH
  } ssi_state_t;

  typedef struct packed {
    logic start;     // capture request, init search bounds and shift pointer
    logic srch_rd;   // read the probe entry
    logic srch_upd;  // compare probe entry, narrow bounds
    logic sh_rd;     // read the entry below the shift pointer
    logic sh_wr;     // write it one place up, step pointer down
    logic key_wr;    // write the new key at its position, bump count
    logic rd_rd;     // read the entry for a read request
    logic finish;    // load the result register
  } ssi_cmd_t;

  typedef struct packed {
    logic is_read;
    logic lo_lt_hi;
    logic ptr_gt_pos;
    logic dup;
    logic full;
    logic out_free;
  } ssi_status_t;

endpackage

[rtl/ssi_ctrl.sv]
// ----------------------------------------------------------------------------
// ssi_ctrl
// Sequencer of the sorted set insert unit: binary search, shift-up loop,
// key write, indexed read and result hand-off.
// ----------------------------------------------------------------------------
module ssi_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ssi_pkg::ssi_status_t status,
  output ssi_pkg::ssi_cmd_t    cmd
);
  import ssi_pkg::*;

  ssi_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status.is_read) begin
          cmd.rd_rd  = 1'b1;
          state_next = ST_FINISH;
        end else if (status.lo_lt_hi) begin
          cmd.srch_rd = 1'b1;
          state_next  = ST_COMPARE;
        end else if (status.dup || status.full) begin
          state_next = ST_FINISH;
        end else if (status.ptr_gt_pos) begin
          cmd.sh_rd  = 1'b1;
          state_next = ST_SHIFT_WR;
        end else begin
          cmd.key_wr = 1'b1;
          state_next = ST_FINISH;
        end
      end
      ST_COMPARE: begin
        cmd.srch_upd = 1'b1;
        state_next   = ST_SEARCH;
      end
      ST_SHIFT_WR: begin
        cmd.sh_wr  = 1'b1;
        state_next = ST_SHIFT_RD;
      end
      ST_SHIFT_RD: begin
        if (status.ptr_gt_pos) begin
          cmd.sh_rd  = 1'b1;
          state_next = ST_SHIFT_WR;
        end else begin
          cmd.key_wr = 1'b1;
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/ssi_datapath.sv]
// ----------------------------------------------------------------------------
// ssi_datapath
// Key store, search bounds, shift pointer, entry count and result register
// of the sorted set insert unit.
// ----------------------------------------------------------------------------
module ssi_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ssi_pkg::ssi_cmd_t                  cmd,
  output ssi_pkg::ssi_status_t               status,
  input  logic                               kind,
  input  logic signed [ssi_pkg::KEY_W-1:0]   new_key,
  input  logic [ssi_pkg::IDX_W-1:0]          read_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               inserted,
  output logic                               duplicate,
  output logic                               full_drop,
  output logic [ssi_pkg::OUT_C_W-1:0]        position,
  output logic [ssi_pkg::OUT_C_W-1:0]        entry_count,
  output logic signed [ssi_pkg::KEY_W-1:0]   read_key
);
  import ssi_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = (CW > IDX_W) ? CW : IDX_W;
  localparam int OW   = (CW > OUT_C_W) ? CW : OUT_C_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic signed [KEY_W-1:0] store [CAPACITY];
  logic signed [KEY_W-1:0] rdata;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic signed [KEY_W-1:0] wr_data;

  logic                    kind_r;
  logic signed [KEY_W-1:0] key;
  logic [IW-1:0]           ridx;
  logic                    rd_hit;
  logic                    full_r;
  logic [CW-1:0]           count;
  logic [CW-1:0]           lo;
  logic [CW-1:0]           hi;
  logic [CW-1:0]           ptr;
  logic                    dup;
  logic [CW:0]             lo_hi_sum;
  logic [AW-1:0]           mid;
  logic [IW-1:0]           ridx_next;
  logic [OW-1:0]           pos_wide;
  logic [OW-1:0]           cnt_wide;

  assign lo_hi_sum = {1'b0, lo} + {1'b0, hi};
  assign mid       = lo_hi_sum[AW:1];
  assign ridx_next = IW'(read_index);

  // key store: one write and one registered read per cycle
  always_comb begin
    rd_en   = cmd.srch_rd | cmd.sh_rd | cmd.rd_rd;
    rd_addr = ridx[AW-1:0];
    if (cmd.srch_rd) begin
      rd_addr = mid;
    end else if (cmd.sh_rd) begin
      rd_addr = AW'(ptr - CW'(1));
    end
    wr_en   = cmd.sh_wr | cmd.key_wr;
    wr_addr = cmd.sh_wr ? ptr[AW-1:0] : lo[AW-1:0];
    wr_data = cmd.sh_wr ? rdata : key;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= store[rd_addr];
    end
  end

  // request capture, search and shift bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_r <= kind;
      key    <= new_key;
      ridx   <= ridx_next;
      rd_hit <= ridx_next < IW'(count);
      // full state as seen by this request, before its own key goes in
      full_r <= (count == CAP_C);
      lo     <= '0;
      hi     <= count;
      ptr    <= count;
      dup    <= 1'b0;
    end else begin
      if (cmd.srch_upd) begin
        if (rdata < key) begin
          lo <= CW'(mid) + CW'(1);
        end else begin
          hi <= CW'(mid);
          if (rdata == key) begin
            dup <= 1'b1;
          end
        end
      end
      if (cmd.sh_wr) begin
        ptr <= ptr - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.key_wr) begin
      count <= count + CW'(1);
    end
  end

  assign status.is_read    = (kind_r == KIND_READ);
  assign status.lo_lt_hi   = lo < hi;
  assign status.ptr_gt_pos = ptr > lo;
  assign status.dup        = dup;
  assign status.full       = full_r;
  assign status.out_free   = !out_valid || out_ready;

  assign pos_wide = OW'(lo);
  assign cnt_wide = OW'(count);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      entry_count <= cnt_wide[OUT_C_W-1:0];
      if (kind_r == KIND_READ) begin
        inserted  <= 1'b0;
        duplicate <= 1'b0;
        full_drop <= 1'b0;
        position  <= rd_hit ? OUT_C_W'(ridx) : '0;
        read_key  <= rd_hit ? rdata : '0;
      end else begin
        inserted  <= !dup && !status.full;
        duplicate <= dup;
        full_drop <= !dup && status.full;
        position  <= pos_wide[OUT_C_W-1:0];
        read_key  <= '0;
      end
    end
  end

endmodule

[rtl/sorted_set_insert_unit.sv]
// An insert runs S binary search steps (up to ceil(log2(n+1)) for n stored keys), then,
// if it goes in, shifts M = n - position entries up; a read fetches its entry without a
// search. The unit takes one request at a time, with in_ready high only while idle, and the
// key store serves one access at a time; a result held by out_ready low stalls the unit in
// its finish state. Reset clears the entry count and handshake state; store contents stay
// undefined.
// ----------------------------------------------------------------------------
// sorted_set_insert_unit
// Ascending set of distinct signed keys with insert (binary search, shift-up)
// and indexed read, built as a controller and a datapath.
// ----------------------------------------------------------------------------
module sorted_set_insert_unit #(
  parameter int CAPACITY = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               kind,
  input  logic signed [ssi_pkg::KEY_W-1:0]   new_key,
  input  logic [ssi_pkg::IDX_W-1:0]          read_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               inserted,
  output logic                               duplicate,
  output logic                               full_drop,
  output logic [ssi_pkg::OUT_C_W-1:0]        position,
  output logic [ssi_pkg::OUT_C_W-1:0]        entry_count,
  output logic signed [ssi_pkg::KEY_W-1:0]   read_key
);
  import ssi_pkg::*;

  ssi_cmd_t    cmd;
  ssi_status_t status;

  ssi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ssi_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .kind        (kind),
    .new_key     (new_key),
    .read_index  (read_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .inserted    (inserted),
    .duplicate   (duplicate),
    .full_drop   (full_drop),
    .position    (position),
    .entry_count (entry_count),
    .read_key    (read_key)
  );

endmodule

[tb/sv/sorted_set_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_set_checker
// Watches both channels of the sorted set insert unit, keeps a shadow copy of
// the key set, predicts the response to each accepted request and compares
// every accepted response field by field, in order.
// ----------------------------------------------------------------------------
module sorted_set_checker #(
  parameter int CAPACITY = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic                             kind,
  input  logic signed [ssi_pkg::KEY_W-1:0] new_key,
  input  logic [ssi_pkg::IDX_W-1:0]        read_index,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic                             inserted,
  input  logic                             duplicate,
  input  logic                             full_drop,
  input  logic [ssi_pkg::OUT_C_W-1:0]      position,
  input  logic [ssi_pkg::OUT_C_W-1:0]      entry_count,
  input  logic signed [ssi_pkg::KEY_W-1:0] read_key,
  output int                               fail_count,
  output int                               pending_count
);
  import ssi_pkg::*;

  typedef struct packed {
    logic                     inserted;
    logic                     duplicate;
    logic                     full_drop;
    logic [OUT_C_W-1:0]       position;
    logic [OUT_C_W-1:0]       entry_count;
    logic signed [KEY_W-1:0]  read_key;
  } set_response_t;

  logic signed [KEY_W-1:0] shadow_keys [CAPACITY];
  int                      shadow_count;
  set_response_t           expected_responses [$];

  // update the shadow set and queue the response this request must produce
  task automatic apply_request(input logic req_kind, input logic signed [KEY_W-1:0] key,
                               input logic [IDX_W-1:0] idx);
    set_response_t rsp;
    int            slot;
    int            i;
    rsp = '0;
    if (req_kind == KIND_INSERT) begin
      slot = 0;
      while (slot < shadow_count && shadow_keys[slot] < key) slot++;
      if (slot < shadow_count && shadow_keys[slot] == key) begin
        rsp.duplicate = 1'b1;
      end else if (shadow_count >= CAPACITY) begin
        rsp.full_drop = 1'b1;
      end else begin
        for (i = shadow_count; i > slot; i--) shadow_keys[i] = shadow_keys[i-1];
        shadow_keys[slot] = key;
        shadow_count++;
        rsp.inserted = 1'b1;
      end
      rsp.position = OUT_C_W'(slot);
    end else if (int'(idx) < shadow_count) begin
      rsp.read_key = shadow_keys[idx];
      rsp.position = OUT_C_W'(idx);
    end
    rsp.entry_count = OUT_C_W'(shadow_count);
    expected_responses.insert(expected_responses.size(), rsp);
  endtask

  task automatic compare_field(input string field, input logic [KEY_W-1:0] want,
                               input logic [KEY_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    set_response_t want;
    if (rst) begin
      shadow_count = 0;
      fail_count = 0;
      expected_responses.delete();
    end else begin
      // a response can never belong to a request taken at the same edge
      if (out_valid && out_ready) begin
        if (expected_responses.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: response with no request outstanding", $time);
        end else begin
          want = expected_responses.pop_front();
          compare_field("inserted", KEY_W'(want.inserted), KEY_W'(inserted));
          compare_field("duplicate", KEY_W'(want.duplicate), KEY_W'(duplicate));
          compare_field("full_drop", KEY_W'(want.full_drop), KEY_W'(full_drop));
          compare_field("position", KEY_W'(want.position), KEY_W'(position));
          compare_field("entry_count", KEY_W'(want.entry_count), KEY_W'(entry_count));
          compare_field("read_key", want.read_key, read_key);
        end
      end
      if (in_valid && in_ready) apply_request(kind, new_key, read_index);
    end
    pending_count = expected_responses.size();
  end

endmodule

[tb/sv/tb_sorted_set_insert_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_set_insert_unit
// Drives insert and read requests into the sorted set insert unit: a directed
// run over key extremes, duplicates and out-of-range reads, then random
// requests that fill the store and keep hitting it once full. Both channels
// idle at random. A separate checker predicts and compares the responses.
// ----------------------------------------------------------------------------
module tb_sorted_set_insert_unit;
  import ssi_pkg::*;

  localparam int SET_CAPACITY    = 64;
  localparam int RANDOM_REQUESTS = 800;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int DRAIN_CYCLES    = 300;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic                    kind;
  logic signed [KEY_W-1:0] new_key;
  logic [IDX_W-1:0]        read_index;
  logic                    out_valid;
  logic                    out_ready;
  logic                    inserted;
  logic                    duplicate;
  logic                    full_drop;
  logic [OUT_C_W-1:0]      position;
  logic [OUT_C_W-1:0]      entry_count;
  logic signed [KEY_W-1:0] read_key;

  int                      fail_count;
  int                      pending_count;
  int                      idle_cycles = 0;
  logic                    no_stall = 1'b0;
  logic signed [KEY_W-1:0] issued_keys [$];

  sorted_set_insert_unit #(
    .CAPACITY(SET_CAPACITY)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .new_key(new_key),
    .read_index(read_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .inserted(inserted),
    .duplicate(duplicate),
    .full_drop(full_drop),
    .position(position),
    .entry_count(entry_count),
    .read_key(read_key)
  );

  sorted_set_checker #(
    .CAPACITY(SET_CAPACITY)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .new_key(new_key),
    .read_index(read_index),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .inserted(inserted),
    .duplicate(duplicate),
    .full_drop(full_drop),
    .position(position),
    .entry_count(entry_count),
    .read_key(read_key),
    .fail_count(fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones, none during steady stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_stall || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  initial begin
    forever begin
      repeat ($urandom_range(300, 800)) @(posedge clk);
      no_stall <= 1'b1;
      repeat ($urandom_range(50, 200)) @(posedge clk);
      no_stall <= 1'b0;
    end
  end

  initial begin
    int stall;
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_request(input logic req_kind, input logic signed [KEY_W-1:0] key,
                              input logic [IDX_W-1:0] idx);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= req_kind;
    new_key    <= key;
    read_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // the unused field carries noise
  task automatic insert_key(input logic signed [KEY_W-1:0] key);
    issued_keys.insert(issued_keys.size(), key);
    send_request(KIND_INSERT, key, IDX_W'($urandom_range(0, 63)));
  endtask

  task automatic read_entry(input logic [IDX_W-1:0] idx);
    send_request(KIND_READ, $urandom, idx);
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30 && issued_keys.size() > 0)
      return issued_keys[$urandom_range(0, issued_keys.size() - 1)];
    if (r < 50) return $urandom_range(0, 16) - 8;
    if (r < 60) begin
      case ($urandom_range(0, 5))
        0: return 32'h8000_0000;
        1: return 32'h8000_0001;
        2: return 32'h7fff_ffff;
        3: return 32'h7fff_fffe;
        4: return 32'hffff_ffff;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom;
  endfunction

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    kind       <= KIND_INSERT;
    new_key    <= '0;
    read_index <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty store reads, then extremes and duplicates
    read_entry(6'd0);
    read_entry(6'd63);
    insert_key(32'h0000_0000);
    insert_key(32'h0000_0000);
    insert_key(32'h7fff_ffff);
    insert_key(32'h8000_0000);
    insert_key(32'hffff_ffff);
    insert_key(32'h0000_0001);
    insert_key(32'h8000_0001);
    insert_key(32'h7fff_fffe);
    insert_key(32'haaaa_aaaa);
    insert_key(32'h5555_5555);
    insert_key(32'h8000_0000);
    insert_key(32'h7fff_ffff);
    read_entry(6'd0);
    read_entry(6'd8);
    read_entry(6'd9);
    read_entry(6'd10);
    read_entry(6'd63);
    read_entry(6'd21);

    repeat (RANDOM_REQUESTS) begin
      if ($urandom_range(0, 99) < 35) read_entry(IDX_W'($urandom_range(0, 63)));
      else insert_key(pick_key());
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
